// ===== src/ffba_pkg.sv =====
// ffba_pkg: shared types, codes and constants of the first-fit block allocator
// no dependencies; compiled before every other file of the block

package ffba_pkg;

    // fixed field widths
    localparam int WORD_W    = 32;
    localparam int TYPE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int HDR_W     = 8;
    localparam int CFG_IDX_W = 2;

    // defaults for the top-level parameters
    localparam int MAX_BLOCKS_DEF = 64;
    localparam int ADDR_BITS_DEF  = 32;

    // command queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = 2'd2;

    // configuration reset values
    localparam logic [WORD_W-1:0] HEAP_BASE_RST   = 32'h0000_0000;
    localparam logic [WORD_W-1:0] HEAP_LIMIT_RST  = 32'hFFFF_FFFF;
    localparam logic [HDR_W-1:0]  HEADER_SIZE_RST = 8'd24;

    // request types
    typedef enum logic [TYPE_W-1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_RESIZE = 2'd2,
        REQ_ZALLOC = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    // work kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_DONE   = 2'd0,
        CMD_ALLOC  = 2'd1,
        CMD_FREE   = 2'd2,
        CMD_RESIZE = 2'd3
    } t_cmd_kind;

    // classified command
    typedef struct packed {
        t_cmd_kind         kind;
        t_status           status;
        logic              zero_fill;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] addr;
    } t_cmd;

endpackage

// ===== src/ffba_if.sv =====
// ffba_if: request and response channel interfaces of the allocator
// depends on ffba_pkg for field widths

interface ffba_req_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::TYPE_W-1:0]    req_type;
    logic [ffba_pkg::WORD_W-1:0]    req_size;
    logic [ffba_pkg::WORD_W-1:0]    req_address;
    logic [ffba_pkg::WORD_W-1:0]    element_count;
    logic [ffba_pkg::WORD_W-1:0]    element_bytes;

    modport source (
        output valid, req_type, req_size, req_address, element_count, element_bytes,
        input  ready
    );
    modport sink (
        input  valid, req_type, req_size, req_address, element_count, element_bytes,
        output ready
    );
endinterface

interface ffba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::STATUS_W-1:0]  status;
    logic [ffba_pkg::WORD_W-1:0]    data_address;
    logic [ffba_pkg::WORD_W-1:0]    copy_from;
    logic [ffba_pkg::WORD_W-1:0]    copy_bytes;
    logic [ffba_pkg::WORD_W-1:0]    zero_fill_bytes;

    modport source (
        output valid, status, data_address, copy_from, copy_bytes, zero_fill_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, data_address, copy_from, copy_bytes, zero_fill_bytes,
        output ready
    );
endinterface

// ===== src/first_fit_block_allocator.sv =====
// first_fit_block_allocator: heap block allocator with a first-fit table
// depends on ffba_pkg, ffba_if, ffba_front, ffba_queue, ffba_back
//
// Usage:
//   i_req carries allocate, free, resize and zeroed-allocate transactions;
//   o_rsp returns exactly one result transaction per request, in order.
//   The write port (i_cfg_we, i_cfg_index, i_cfg_data) sets heap_base,
//   heap_limit and header_size; write it only while no request is pending.
//   The front registers each request and hands it to the queue. The back scans
//   the block table one entry per cycle through its single read port; a
//   request settled in the front (zero size, null free) still passes through
//   the back. The next request starts in the back when the previous result
//   sits in the response register, so the back serves one request at a time.
//   Reset clears the block count, so the table needs no clearing pass; the
//   configuration returns to base 0, limit all ones, header 24 bytes.
//   When o_rsp stalls, the response register holds its result, the back
//   finishes at most one more request and the queue and front then fill
//   and drop i_req.ready.

module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ffba_req_if.sink                        i_req,
    ffba_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffba_pkg::WORD_W-1:0]     i_cfg_data
);
    import ffba_pkg::*;

    logic  front_vld;
    t_cmd  front_cmd;
    logic  queue_ready;
    logic  queue_vld;
    t_cmd  queue_cmd;
    logic  back_pop;

    // request decode
    ffba_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (front_vld),
        .o_cmd       (front_cmd),
        .i_cmd_ready (queue_ready)
    );

    // command queue
    ffba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_data  (front_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_vld),
        .o_data  (queue_cmd),
        .i_pop   (back_pop)
    );

    // table engine
    ffba_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_vld),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (back_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== src/ffba_front.sv =====
// ffba_front: accepts request transactions, forms the zeroed-allocate size
// and classifies each request into a command; depends on ffba_pkg, ffba_if

module ffba_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ffba_req_if.sink         i_req,
    output logic             o_cmd_valid,
    output ffba_pkg::t_cmd   o_cmd,
    input  logic             i_cmd_ready
);
    import ffba_pkg::*;

    logic                    r_vld;
    t_req                    r_type;
    logic [WORD_W-1:0]       r_size;
    logic [WORD_W-1:0]       r_addr;
    logic [2*WORD_W-1:0]     r_prod;
    logic [WORD_W-1:0]       total;

    assign i_req.ready = !r_vld || i_cmd_ready;
    assign o_cmd_valid = r_vld;

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_vld <= i_req.valid;
        end
    end

    // input stage payload, element product registered
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_type <= t_req'(i_req.req_type);
            r_size <= i_req.req_size;
            r_addr <= i_req.req_address;
            r_prod <= (2*WORD_W)'(i_req.element_count) * (2*WORD_W)'(i_req.element_bytes);
        end
    end

    // saturate the product to one word
    assign total = (|r_prod[2*WORD_W-1:WORD_W]) ? '1 : r_prod[WORD_W-1:0];

    // classify
    always_comb begin
        o_cmd.kind      = CMD_DONE;
        o_cmd.status    = ST_OK;
        o_cmd.zero_fill = 1'b0;
        o_cmd.size      = r_size;
        o_cmd.addr      = r_addr;
        unique case (r_type)
            REQ_ALLOC: begin
                if (r_size == '0) begin
                    o_cmd.status = ST_ZERO;
                end else begin
                    o_cmd.kind = CMD_ALLOC;
                end
            end
            REQ_FREE: begin
                // null free is ignored
                if (r_addr != '0) begin
                    o_cmd.kind = CMD_FREE;
                end
            end
            REQ_RESIZE: begin
                if (r_addr != '0) begin
                    o_cmd.kind = CMD_RESIZE;
                end else if (r_size == '0) begin
                    o_cmd.status = ST_ZERO;
                end else begin
                    o_cmd.kind = CMD_ALLOC;
                end
            end
            REQ_ZALLOC: begin
                o_cmd.size = total;
                if (total == '0) begin
                    o_cmd.status = ST_ZERO;
                end else begin
                    o_cmd.kind      = CMD_ALLOC;
                    o_cmd.zero_fill = 1'b1;
                end
            end
            default: begin
                o_cmd.kind = CMD_DONE;
            end
        endcase
    end

endmodule

// ===== src/ffba_queue.sv =====
// ffba_queue: short command queue decoupling front and back
// depends on ffba_pkg for the command type and depth

module ffba_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ffba_pkg::t_cmd   i_data,
    output logic             o_ready,
    output logic             o_valid,
    output ffba_pkg::t_cmd   o_data,
    input  logic             i_pop
);
    import ffba_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [QW:0] FULL = (QW+1)'(QUEUE_DEPTH);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QW-1:0]     r_wr_ptr;
    logic [QW-1:0]     r_rd_ptr;
    logic [QW:0]       r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QW+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/ffba_back.sv =====
// ffba_back: block table, first-fit scan engine, heap growth, configuration
// registers and response register; depends on ffba_pkg, ffba_if

module ffba_back #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ffba_pkg::ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  ffba_pkg::t_cmd                  i_cmd,
    output logic                            o_cmd_pop,
    input  logic                            i_cfg_we,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ffba_pkg::WORD_W-1:0]     i_cfg_data,
    ffba_rsp_if.source                      o_rsp
);
    import ffba_pkg::*;

    localparam int IDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
    localparam int LIM_BITS = (ADDR_BITS < WORD_W) ? ADDR_BITS : WORD_W;
    localparam logic [WORD_W:0]  ADDR_MAX  =
        ((WORD_W+1)'(1) << LIM_BITS) - (WORD_W+1)'(1);
    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_BLOCKS);

    typedef struct packed {
        logic [WORD_W-1:0] start;
        logic [WORD_W-1:0] size;
        logic              is_free;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN     = 6'b000010,
        S_PLACE    = 6'b000100,
        S_APPEND   = 6'b001000,
        S_FREE_OLD = 6'b010000,
        S_DONE     = 6'b100000
    } t_state;

    // block table
    t_entry              r_mem [MAX_BLOCKS];
    t_entry              r_rd_data;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    t_entry              mem_wdata;
    logic                rd_en;

    // control
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [WORD_W:0]     r_break, n_break;
    logic [CNT_W-1:0]    r_iss_idx, n_iss_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_out_vld, n_out_vld;
    logic [WORD_W-1:0]   r_heap_base, n_heap_base;
    logic [WORD_W-1:0]   r_heap_limit, n_heap_limit;
    logic [HDR_W-1:0]    r_header_size, n_header_size;

    // command payload and scan context
    t_cmd_kind           r_kind, n_kind;
    logic                r_zero_fill, n_zero_fill;
    logic [WORD_W-1:0]   r_size, n_size;
    logic [WORD_W-1:0]   r_addr, n_addr;
    logic                r_fit, n_fit;
    logic [IDX_W-1:0]    r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]    r_old_idx, n_old_idx;
    logic [WORD_W-1:0]   r_old_size, n_old_size;
    logic [WORD_W+1:0]   r_data_pos, n_data_pos;
    logic [WORD_W:0]     r_lim, n_lim;

    // result in progress and response register
    t_status             r_res_status, n_res_status;
    logic [WORD_W-1:0]   r_res_data, n_res_data;
    logic [WORD_W-1:0]   r_res_cfrom, n_res_cfrom;
    logic [WORD_W-1:0]   r_res_cbytes, n_res_cbytes;
    logic [WORD_W-1:0]   r_res_zfill, n_res_zfill;
    t_status             r_out_status, n_out_status;
    logic [WORD_W-1:0]   r_out_data, n_out_data;
    logic [WORD_W-1:0]   r_out_cfrom, n_out_cfrom;
    logic [WORD_W-1:0]   r_out_cbytes, n_out_cbytes;
    logic [WORD_W-1:0]   r_out_zfill, n_out_zfill;

    logic                hit_lookup;
    logic                hit_fit;
    logic                scan_end;
    logic                out_free;
    logic [WORD_W+2:0]   append_end;

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.data_address    = r_out_data;
    assign o_rsp.copy_from       = r_out_cfrom;
    assign o_rsp.copy_bytes      = r_out_cbytes;
    assign o_rsp.zero_fill_bytes = r_out_zfill;

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_iss_idx[IDX_W-1:0]];
        end
    end

    // compare of the entry read in the previous cycle
    assign hit_lookup = r_cmp_vld && (r_rd_data.start == r_addr);
    assign hit_fit    = r_cmp_vld && r_rd_data.is_free && (r_rd_data.size >= r_size);
    assign scan_end   = (r_iss_idx == r_count) && !r_cmp_vld;
    assign out_free   = !r_out_vld || o_rsp.ready;
    assign append_end = (WORD_W+3)'(r_data_pos) + (WORD_W+3)'(r_size);

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_break       = r_break;
        n_iss_idx     = r_iss_idx;
        n_cmp_vld     = r_cmp_vld;
        n_out_vld     = r_out_vld;
        n_heap_base   = r_heap_base;
        n_heap_limit  = r_heap_limit;
        n_header_size = r_header_size;
        n_kind        = r_kind;
        n_zero_fill   = r_zero_fill;
        n_size        = r_size;
        n_addr        = r_addr;
        n_fit         = r_fit;
        n_cmp_idx     = r_cmp_idx;
        n_old_idx     = r_old_idx;
        n_old_size    = r_old_size;
        n_data_pos    = r_data_pos;
        n_lim         = r_lim;
        n_res_status  = r_res_status;
        n_res_data    = r_res_data;
        n_res_cfrom   = r_res_cfrom;
        n_res_cbytes  = r_res_cbytes;
        n_res_zfill   = r_res_zfill;
        n_out_status  = r_out_status;
        n_out_data    = r_out_data;
        n_out_cfrom   = r_out_cfrom;
        n_out_cbytes  = r_out_cbytes;
        n_out_zfill   = r_out_zfill;
        o_cmd_pop     = 1'b0;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_cmp_idx;
        mem_wdata     = r_rd_data;

        // response transaction taken
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop    = 1'b1;
                    n_kind       = i_cmd.kind;
                    n_zero_fill  = i_cmd.zero_fill;
                    n_size       = i_cmd.size;
                    n_addr       = i_cmd.addr;
                    n_fit        = (i_cmd.kind == CMD_ALLOC);
                    n_iss_idx    = '0;
                    n_cmp_vld    = 1'b0;
                    n_res_status = i_cmd.status;
                    n_res_data   = '0;
                    n_res_cfrom  = '0;
                    n_res_cbytes = '0;
                    n_res_zfill  = '0;
                    n_state      = (i_cmd.kind == CMD_DONE) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // issue the next read
                if (r_iss_idx != r_count) begin
                    rd_en     = 1'b1;
                    n_iss_idx = r_iss_idx + CNT_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_iss_idx[IDX_W-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
                if (r_fit && hit_fit) begin
                    // first free entry that fits, no split
                    n_cmp_vld         = 1'b0;
                    mem_we            = 1'b1;
                    mem_wdata.is_free = 1'b0;
                    n_res_data        = r_rd_data.start;
                    n_res_zfill       = r_zero_fill ? r_size : '0;
                    n_state           = (r_kind == CMD_RESIZE) ? S_FREE_OLD : S_DONE;
                end else if (!r_fit && hit_lookup) begin
                    n_cmp_vld = 1'b0;
                    if (r_kind == CMD_FREE) begin
                        mem_we            = 1'b1;
                        mem_wdata.is_free = 1'b1;
                        n_state           = S_DONE;
                    end else if (r_rd_data.size >= r_size) begin
                        // resize in place
                        n_res_data = r_addr;
                        n_state    = S_DONE;
                    end else begin
                        // moving resize: rescan for a fit
                        n_old_idx  = r_cmp_idx;
                        n_old_size = r_rd_data.size;
                        n_fit      = 1'b1;
                        n_iss_idx  = '0;
                    end
                end else if (scan_end) begin
                    if (r_fit) begin
                        n_state = S_PLACE;
                    end else begin
                        n_res_status = ST_UNKNOWN;
                        n_state      = S_DONE;
                    end
                end
            end
            S_PLACE: begin
                // table-full check, header position and effective limit
                if (r_count == COUNT_MAX) begin
                    n_res_status = ST_NOSPACE;
                    n_state      = S_DONE;
                end else begin
                    n_data_pos = (WORD_W+2)'(r_break) + (WORD_W+2)'(r_header_size);
                    n_lim      = ({1'b0, r_heap_limit} > ADDR_MAX) ? ADDR_MAX
                                                                 : {1'b0, r_heap_limit};
                    n_state    = S_APPEND;
                end
            end
            S_APPEND: begin
                if (append_end > (WORD_W+3)'(r_lim)) begin
                    n_res_status = ST_NOSPACE;
                    n_state      = S_DONE;
                end else begin
                    mem_we            = 1'b1;
                    mem_waddr         = r_count[IDX_W-1:0];
                    mem_wdata.start   = r_data_pos[WORD_W-1:0];
                    mem_wdata.size    = r_size;
                    mem_wdata.is_free = 1'b0;
                    n_count           = r_count + CNT_W'(1);
                    n_break           = append_end[WORD_W:0];
                    n_res_data        = r_data_pos[WORD_W-1:0];
                    n_res_zfill       = r_zero_fill ? r_size : '0;
                    n_state           = (r_kind == CMD_RESIZE) ? S_FREE_OLD : S_DONE;
                end
            end
            S_FREE_OLD: begin
                // release the old block of a moving resize
                mem_we            = 1'b1;
                mem_waddr         = r_old_idx;
                mem_wdata.start   = r_addr;
                mem_wdata.size    = r_old_size;
                mem_wdata.is_free = 1'b1;
                n_res_cfrom       = r_addr;
                n_res_cbytes      = r_old_size;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_data   = r_res_data;
                    n_out_cfrom  = r_res_cfrom;
                    n_out_cbytes = r_res_cbytes;
                    n_out_zfill  = r_res_zfill;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // configuration writes, to be made only while idle; the block does not enforce it
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEAP_BASE: begin
                    n_heap_base = i_cfg_data;
                    if (r_count == '0) begin
                        n_break = {1'b0, i_cfg_data};
                    end
                end
                CFG_HEAP_LIMIT: begin
                    n_heap_limit = i_cfg_data;
                end
                CFG_HEADER_SIZE: begin
                    n_header_size = i_cfg_data[HDR_W-1:0];
                end
                default: begin
                    n_heap_limit = r_heap_limit;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_break       <= {1'b0, HEAP_BASE_RST};
            r_iss_idx     <= '0;
            r_cmp_vld     <= 1'b0;
            r_out_vld     <= 1'b0;
            r_heap_base   <= HEAP_BASE_RST;
            r_heap_limit  <= HEAP_LIMIT_RST;
            r_header_size <= HEADER_SIZE_RST;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_break       <= n_break;
            r_iss_idx     <= n_iss_idx;
            r_cmp_vld     <= n_cmp_vld;
            r_out_vld     <= n_out_vld;
            r_heap_base   <= n_heap_base;
            r_heap_limit  <= n_heap_limit;
            r_header_size <= n_header_size;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_zero_fill  <= n_zero_fill;
        r_size       <= n_size;
        r_addr       <= n_addr;
        r_fit        <= n_fit;
        r_cmp_idx    <= n_cmp_idx;
        r_old_idx    <= n_old_idx;
        r_old_size   <= n_old_size;
        r_data_pos   <= n_data_pos;
        r_lim        <= n_lim;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_cfrom  <= n_res_cfrom;
        r_res_cbytes <= n_res_cbytes;
        r_res_zfill  <= n_res_zfill;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_cfrom  <= n_out_cfrom;
        r_out_cbytes <= n_out_cbytes;
        r_out_zfill  <= n_out_zfill;
    end

endmodule

// ===== src/ffba_checker.sv =====
// ffba_checker: port-level assertions on the allocator response channel
// depends on ffba_pkg; bound to first_fit_block_allocator below

module ffba_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [ffba_pkg::STATUS_W-1:0]   i_rsp_status,
    input  logic [ffba_pkg::WORD_W-1:0]     i_rsp_data_address,
    input  logic [ffba_pkg::WORD_W-1:0]     i_rsp_copy_from,
    input  logic [ffba_pkg::WORD_W-1:0]     i_rsp_copy_bytes,
    input  logic [ffba_pkg::WORD_W-1:0]     i_rsp_zero_fill_bytes
);
    import ffba_pkg::*;

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status)
            && $stable(i_rsp_data_address) && $stable(i_rsp_copy_from)
            && $stable(i_rsp_copy_bytes) && $stable(i_rsp_zero_fill_bytes))
        else $error("response changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

    // failures return a null address
    a_fail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |-> i_rsp_data_address == '0)
        else $error("failed request returned an address");

    // a copy descriptor only comes with a successful move of a nonempty block
    a_copy_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_copy_from != '0)
            |-> (i_rsp_status == ST_OK) && (i_rsp_copy_bytes != '0))
        else $error("copy descriptor on a failed or empty move");

    // zero fill only on success
    a_zfill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_zero_fill_bytes != '0) |-> i_rsp_status == ST_OK)
        else $error("zero fill on a failed request");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_rsp_valid           (o_rsp.valid),
    .i_rsp_ready           (o_rsp.ready),
    .i_rsp_status          (o_rsp.status),
    .i_rsp_data_address    (o_rsp.data_address),
    .i_rsp_copy_from       (o_rsp.copy_from),
    .i_rsp_copy_bytes      (o_rsp.copy_bytes),
    .i_rsp_zero_fill_bytes (o_rsp.zero_fill_bytes)
);

// ===== dv/tb.sv =====
// tb: self-checking testbench for first_fit_block_allocator
// depends on ffba_pkg, ffba_if and the allocator rtl; checks every response
// against a block-table model kept alongside the stimulus

`timescale 1ns / 100ps

module tb;
    import ffba_pkg::*;

    localparam int TBL_DEPTH      = MAX_BLOCKS_DEF;
    localparam int SETTLE_CYCLES  = 2 * MAX_BLOCKS_DEF + 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        t_req              kind;
        logic [WORD_W-1:0] size;
        logic [WORD_W-1:0] addr;
        logic [WORD_W-1:0] count;
        logic [WORD_W-1:0] each;
    } t_req_item;

    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] data;
        logic [WORD_W-1:0] cfrom;
        logic [WORD_W-1:0] cbytes;
        logic [WORD_W-1:0] zfill;
    } t_rsp_item;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // heap model state
    logic [WORD_W-1:0] tbl_start [TBL_DEPTH];
    logic [WORD_W-1:0] tbl_size  [TBL_DEPTH];
    logic              tbl_free  [TBL_DEPTH];
    int                tbl_count;
    logic [63:0]       brk;
    logic [WORD_W-1:0] cfg_base;
    logic [WORD_W-1:0] cfg_limit;
    logic [HDR_W-1:0]  cfg_hdr;

    t_rsp_item owed [$];
    int        fail_count = 0;
    bit        src_gaps   = 1'b1;
    bit        sink_gaps  = 1'b1;
    bit        hold_req   = 1'b0;

    function automatic void clear_heap_model();
        int i;
        for (i = 0; i < TBL_DEPTH; i++) begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
            tbl_free[i]  = 1'b0;
        end
        tbl_count = 0;
        cfg_base  = HEAP_BASE_RST;
        cfg_limit = HEAP_LIMIT_RST;
        cfg_hdr   = HEADER_SIZE_RST;
        brk       = {32'h0, HEAP_BASE_RST};
    endfunction

    function automatic int find_entry(input logic [WORD_W-1:0] addr);
        int i;
        for (i = 0; i < tbl_count; i++)
            if (tbl_start[i] == addr) return i;
        return -1;
    endfunction

    // first fit over the table, else append at the break
    function automatic t_status carve_block(input logic [WORD_W-1:0] size,
                                            output logic [WORD_W-1:0] addr);
        int          i;
        logic [63:0] data_a;
        logic [63:0] end_a;
        addr = '0;
        if (size == 0) return ST_ZERO;
        for (i = 0; i < tbl_count; i++) begin
            if (tbl_free[i] && tbl_size[i] >= size) begin
                tbl_free[i] = 1'b0;
                addr = tbl_start[i];
                return ST_OK;
            end
        end
        if (tbl_count >= TBL_DEPTH) return ST_NOSPACE;
        data_a = brk + {56'h0, cfg_hdr};
        end_a  = data_a + {32'h0, size};
        if (end_a > {32'h0, cfg_limit}) return ST_NOSPACE;
        tbl_start[tbl_count] = data_a[31:0];
        tbl_size[tbl_count]  = size;
        tbl_free[tbl_count]  = 1'b0;
        tbl_count++;
        brk  = end_a;
        addr = data_a[31:0];
        return ST_OK;
    endfunction

    // applies one request to the heap model and returns its response
    function automatic t_rsp_item serve_request(input t_req_item it);
        t_rsp_item         r;
        int                idx;
        logic [63:0]       prod;
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] a;
        r = '0;
        r.status = ST_OK;
        case (it.kind)
            REQ_ALLOC: begin
                r.status = carve_block(it.size, a);
                r.data = a;
            end
            REQ_FREE: begin
                if (it.addr != 0) begin
                    idx = find_entry(it.addr);
                    if (idx < 0) r.status = ST_UNKNOWN;
                    else tbl_free[idx] = 1'b1;
                end
            end
            REQ_RESIZE: begin
                if (it.addr == 0) begin
                    r.status = carve_block(it.size, a);
                    r.data = a;
                end else begin
                    idx = find_entry(it.addr);
                    if (idx < 0) begin
                        r.status = ST_UNKNOWN;
                    end else if (tbl_size[idx] >= it.size) begin
                        r.data = it.addr;
                    end else begin
                        r.status = carve_block(it.size, a);
                        r.data = a;
                        if (r.status == ST_OK) begin
                            r.cfrom  = it.addr;
                            r.cbytes = tbl_size[idx];
                            tbl_free[idx] = 1'b1;
                        end
                    end
                end
            end
            default: begin
                prod  = {32'h0, it.count} * {32'h0, it.each};
                total = (prod[63:32] != 0) ? '1 : prod[31:0];
                r.status = carve_block(total, a);
                r.data = a;
                if (r.status == ST_OK) r.zfill = total;
            end
        endcase
        return r;
    endfunction

    function automatic t_req_item mk(input t_req kind, input logic [WORD_W-1:0] size,
                                     input logic [WORD_W-1:0] addr,
                                     input logic [WORD_W-1:0] count = 0,
                                     input logic [WORD_W-1:0] each = 0);
        t_req_item it;
        it.kind  = kind;
        it.size  = size;
        it.addr  = addr;
        it.count = count;
        it.each  = each;
        return it;
    endfunction

    // mostly small sizes so blocks get reused, some huge ones
    function automatic logic [WORD_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 8) return $urandom();
        if (r < 10) return '1;
        if (r < 40) return $urandom_range(1, 16);
        return $urandom_range(1, 512);
    endfunction

    // live table addresses most of the time, null and stray ones otherwise
    function automatic logic [WORD_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && tbl_count > 0) return tbl_start[$urandom_range(0, tbl_count - 1)];
        if (r < 83) return '0;
        if (r < 90 && tbl_count > 0)
            return tbl_start[$urandom_range(0, tbl_count - 1)] + $urandom_range(1, 3);
        return $urandom();
    endfunction

    function automatic t_req_item random_request();
        t_req_item it;
        int        r;
        it.size  = $urandom();
        it.addr  = $urandom();
        it.count = $urandom();
        it.each  = $urandom();
        r = $urandom_range(0, 99);
        if (r < 35) begin
            it.kind = REQ_ALLOC;
            it.size = pick_size();
        end else if (r < 60) begin
            it.kind = REQ_FREE;
            it.addr = pick_addr();
        end else if (r < 85) begin
            it.kind = REQ_RESIZE;
            it.size = pick_size();
            it.addr = pick_addr();
        end else begin
            it.kind = REQ_ZALLOC;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                it.count = $urandom_range(0, 12);
                it.each  = $urandom_range(1, 64);
            end else if (r < 85) begin
                it.each = $urandom_range(0, 3);
            end
        end
        return it;
    endfunction

    // one request transaction; valid stays up when the next follows directly
    task automatic send_req(input t_req_item it, output t_rsp_item want);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= it.kind;
        req_ch.req_size      <= it.size;
        req_ch.req_address   <= it.addr;
        req_ch.element_count <= it.count;
        req_ch.element_bytes <= it.each;
        do @(posedge i_clk); while (!req_ch.ready);
        want = serve_request(it);
        owed.push_back(want);
    endtask

    // drop valid and wait for all outstanding responses
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_HEAP_BASE: begin
                cfg_base = val;
                if (tbl_count == 0) brk = {32'h0, val};
            end
            CFG_HEAP_LIMIT:  cfg_limit = val;
            CFG_HEADER_SIZE: cfg_hdr = val[HDR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // base moves the break only while the table is empty; null data address
    task automatic test_first_block();
        t_rsp_item r;
        cfg_write(CFG_HEAP_BASE, 32'hFFFF_FFF0);
        send_req(mk(REQ_ALLOC, 1, 0), r);
        cfg_write(CFG_HEAP_BASE, 32'h0);
        cfg_write(CFG_HEADER_SIZE, 32'd0);
        send_req(mk(REQ_ALLOC, 16, 0), r);
        send_req(mk(REQ_FREE, 0, 0), r);
        send_req(mk(REQ_RESIZE, 0, 0), r);
        send_req(mk(REQ_RESIZE, 8, 0), r);
        cfg_write(CFG_HEAP_BASE, 32'h0040_0000);
        send_req(mk(REQ_ALLOC, 4, 0), r);
    endtask

    // zero sizes and saturating element products
    task automatic test_zero_and_overflow();
        t_rsp_item r;
        cfg_write(CFG_HEADER_SIZE, 32'd24);
        send_req(mk(REQ_ALLOC, 0, 0), r);
        send_req(mk(REQ_ZALLOC, 0, 0, 0, 5), r);
        send_req(mk(REQ_ZALLOC, 0, 0, 5, 0), r);
        send_req(mk(REQ_ZALLOC, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), r);
        send_req(mk(REQ_ZALLOC, 0, 0, 32'h0001_0000, 32'h0001_0000), r);
        send_req(mk(REQ_ZALLOC, 0, 0, 4, 8), r);
        send_req(mk(REQ_ALLOC, 32'hFFFF_FFFF, 0), r);
    endtask

    // double free, first-fit reuse and unknown addresses
    task automatic test_free_and_reuse();
        t_rsp_item         r;
        logic [WORD_W-1:0] blk_a;
        send_req(mk(REQ_ALLOC, 100, 0), r);
        blk_a = r.data;
        send_req(mk(REQ_ALLOC, 40, 0), r);
        send_req(mk(REQ_FREE, 0, blk_a), r);
        send_req(mk(REQ_FREE, 0, blk_a), r);
        send_req(mk(REQ_ALLOC, 60, 0), r);
        send_req(mk(REQ_FREE, 0, 32'hDEAD_BEEF), r);
        send_req(mk(REQ_RESIZE, 10, 32'hDEAD_BEEF), r);
    endtask

    // in-place, moving and failed moving resize
    task automatic test_resize();
        t_rsp_item         r;
        logic [WORD_W-1:0] blk_c;
        logic [WORD_W-1:0] blk_d;
        send_req(mk(REQ_ALLOC, 64, 0), r);
        blk_c = r.data;
        send_req(mk(REQ_RESIZE, 32, blk_c), r);
        send_req(mk(REQ_RESIZE, 0, blk_c), r);
        send_req(mk(REQ_RESIZE, 200, blk_c), r);
        blk_d = r.data;
        send_req(mk(REQ_RESIZE, 10, blk_c), r);
        send_req(mk(REQ_RESIZE, 32'hFFFF_FFF0, blk_d), r);
        send_req(mk(REQ_FREE, 0, blk_d), r);
    endtask

    // growth against the heap limit, header extremes
    task automatic test_limits();
        t_rsp_item r;
        cfg_write(CFG_HEAP_LIMIT, brk[31:0] + 32'd74);
        send_req(mk(REQ_ALLOC, 300, 0), r);
        send_req(mk(REQ_ALLOC, 50, 0), r);
        cfg_write(CFG_HEAP_LIMIT, 32'h0);
        send_req(mk(REQ_ALLOC, 1000, 0), r);
        cfg_write(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        cfg_write(CFG_HEADER_SIZE, 32'd255);
        send_req(mk(REQ_ALLOC, 1000, 0), r);
    endtask

    task automatic random_phase(input int n, input logic [WORD_W-1:0] limit,
                                input logic [HDR_W-1:0] hdr);
        t_rsp_item r;
        int        k;
        cfg_write(CFG_HEAP_LIMIT, limit);
        cfg_write(CFG_HEADER_SIZE, {24'h0, hdr});
        for (k = 0; k < n; k++) send_req(random_request(), r);
    endtask

    // response side held off while requests keep coming
    task automatic test_output_stall();
        t_rsp_item r;
        int        k;
        wait_idle();
        src_gaps = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 40; k++) send_req(random_request(), r);
        src_gaps = 1'b1;
        wait_idle();
    endtask

    // append until the table is full, then growth must fail
    task automatic test_table_full();
        t_rsp_item r;
        int        tries;
        cfg_write(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        cfg_write(CFG_HEADER_SIZE, 32'd24);
        tries = 0;
        while (tbl_count < TBL_DEPTH && tries < 200) begin
            send_req(mk(REQ_ALLOC, $urandom_range(1000, 2000), 0), r);
            tries++;
        end
        send_req(mk(REQ_ALLOC, 32'h7FFF_FFFF, 0), r);
        send_req(mk(REQ_ZALLOC, 0, 0, 32'h0000_8000, 32'h0001_0000), r);
    endtask

    // response ready with random stall bursts and one long hold-off
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string label, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            fail_count++;
        end
    endtask

    // compare each response transaction with the oldest owed one
    always @(posedge i_clk) begin : rsp_check
        t_rsp_item want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (owed.size() == 0) begin
                $display("%0t: unexpected response, expected none, actual status %0d addr %h",
                         $time, rsp_ch.status, rsp_ch.data_address);
                fail_count++;
            end else begin
                want = owed.pop_front();
                check_field("status", {30'h0, want.status}, {30'h0, rsp_ch.status});
                check_field("data_address", want.data, rsp_ch.data_address);
                check_field("copy_from", want.cfrom, rsp_ch.copy_from);
                check_field("copy_bytes", want.cbytes, rsp_ch.copy_bytes);
                check_field("zero_fill_bytes", want.zfill, rsp_ch.zero_fill_bytes);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
            else quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_HEAP_BASE;
        cfg_data             <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_ALLOC;
        req_ch.req_size      <= '0;
        req_ch.req_address   <= '0;
        req_ch.element_count <= '0;
        req_ch.element_bytes <= '0;
        clear_heap_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_block();
        test_zero_and_overflow();
        test_free_and_reuse();
        test_resize();
        test_limits();
        random_phase(600, 32'hFFFF_FFFF, 8'($urandom_range(0, 64)));
        random_phase(500, (brk + $urandom_range(0, 3000) > 64'hFFFF_FFFF) ?
                     32'hFFFF_FFFF : 32'(brk + $urandom_range(0, 3000)), 8'd255);
        test_output_stall();
        test_table_full();
        cfg_write(CFG_HEAP_BASE, $urandom());
        random_phase(400, 32'h0, 8'd0);

        // last stretch without idling on either side
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        random_phase(250, 32'hFFFF_FFFF, 8'($urandom_range(0, 255)));
        wait_idle();

        if (fail_count == 0 && owed.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
